@@ src/mkls_pkg.sv @@
// Shared types and constants for the 4x4 line reversal keypad scanner.
// Holds scan phase codes, port drive patterns, the result record and pin decoders.
// No dependencies.
package mkls_pkg;

	localparam int PHASE_W = 3;

	localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
	localparam logic [PHASE_W-1:0] PH_COL_SETTLE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ROW_SETTLE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_RELEASE    = 3'd3;

	localparam logic [7:0] DRIVE_COLS = 8'hF0;
	localparam logic [7:0] DRIVE_ROWS = 8'h0F;

	localparam logic [23:0] DEBOUNCE_RESET = 24'd10;

	typedef struct packed {
		logic [7:0] drive_pattern;
		logic       key_valid;
		logic [3:0] key_code;
		logic       key_error;
	} scan_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} decode_t;

	// Column sample to the column base of the key code.
	function automatic decode_t decode_column(input logic [7:0] pins);
		decode_t d;
		d = '0;
		case (pins)
			8'hE0: d = '{ok: 1'b1, value: 4'd12};
			8'hD0: d = '{ok: 1'b1, value: 4'd13};
			8'hB0: d = '{ok: 1'b1, value: 4'd14};
			8'h70: d = '{ok: 1'b1, value: 4'd15};
			default: d = '{ok: 1'b0, value: 4'd0};
		endcase
		return d;
	endfunction

	// Row sample to the offset taken off the column base.
	function automatic decode_t decode_row(input logic [7:0] pins);
		decode_t d;
		d = '0;
		case (pins)
			8'h07: d = '{ok: 1'b1, value: 4'd12};
			8'h0B: d = '{ok: 1'b1, value: 4'd8};
			8'h0D: d = '{ok: 1'b1, value: 4'd4};
			8'h0E: d = '{ok: 1'b1, value: 4'd0};
			default: d = '{ok: 1'b0, value: 4'd0};
		endcase
		return d;
	endfunction

endpackage

@@ src/mkls_fsm.sv @@
// Scan sequencer: phase register, settle counter and pending key registers.
// Computes one tick's result from the sampled port value and advances on step.
// Depends on mkls_pkg.
module mkls_fsm import mkls_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             pins,
	input  logic [COUNT_WIDTH-1:0] limit,
	output scan_result_t           result
);

	logic [PHASE_W-1:0]     phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [3:0]             col_base_q, col_base_d;
	logic [3:0]             pend_code_q, pend_code_d;
	logic                   pend_err_q, pend_err_d;

	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   settled;
	decode_t                col_dec;
	decode_t                row_dec;
	logic                   row_err;

	// Saturating advance; the debounce ends once the count reaches the limit.
	assign count_inc = (count_q < limit) ? count_q + 1'b1 : count_q;
	assign settled   = (count_inc >= limit);
	assign col_dec   = decode_column(pins);
	assign row_dec   = decode_row(pins);
	assign row_err   = pend_err_q | ~row_dec.ok;

	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		col_base_d  = col_base_q;
		pend_code_d = pend_code_q;
		pend_err_d  = pend_err_q;
		result      = '0;
		case (phase_q)
			PH_COL_SETTLE: begin
				count_d = count_inc;
				if (settled) begin
					if (pins == DRIVE_COLS) begin
						// glitch: drop the press
						phase_d = PH_IDLE;
					end else begin
						col_base_d = col_dec.value;
						pend_err_d = ~col_dec.ok;
						count_d    = '0;
						phase_d    = PH_ROW_SETTLE;
					end
				end
			end
			PH_ROW_SETTLE: begin
				count_d = count_inc;
				if (settled) begin
					pend_err_d  = row_err;
					pend_code_d = row_err ? 4'd0 : col_base_q - row_dec.value;
					phase_d     = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (pins == DRIVE_ROWS) begin
					result.key_valid = 1'b1;
					result.key_error = pend_err_q;
					result.key_code  = pend_err_q ? 4'd0 : pend_code_q;
					count_d          = '0;
					phase_d          = PH_IDLE;
				end
			end
			default: begin
				count_d = '0;
				phase_d = (pins != DRIVE_COLS) ? PH_COL_SETTLE : PH_IDLE;
			end
		endcase
		result.drive_pattern = (phase_d == PH_ROW_SETTLE || phase_d == PH_RELEASE) ?
			DRIVE_ROWS : DRIVE_COLS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			col_base_q  <= '0;
			pend_code_q <= '0;
			pend_err_q  <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			col_base_q  <= col_base_d;
			pend_code_q <= pend_code_d;
			pend_err_q  <= pend_err_d;
		end
	end

endmodule

@@ src/matrix_keypad_line_reversal_scanner_top.sv @@
// Top level of the 4x4 line reversal keypad scanner.
// Input register, scan sequencer (mkls_fsm), result register and debounce setting.
// Depends on mkls_pkg and mkls_fsm.
//
//  channel   signals                                   payload
//  item      item_valid / item_ready                   port_pins
//  result    result_valid / result_ready               drive_pattern, key_valid,
//                                                      key_code, key_error
//  cfg       cfg_valid / cfg_ready                     debounce_ticks
//
// One sample per cycle unless the result stalls; each sample yields one result, passing
// the input register, then the result register. The sequencer state advances as a
// sample leaves the input register. Reset puts the scanner idle driving columns with
// a debounce of 10 ticks. A stalled result holds both registers; item_ready stays high
// while the result register is empty or being taken. cfg_ready is always high.
module matrix_keypad_line_reversal_scanner_top import mkls_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  port_pins,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  drive_pattern,
	output logic        key_valid,
	output logic [3:0]  key_code,
	output logic        key_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] debounce_ticks
);

	localparam int LIM_W = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;
	localparam logic [LIM_W-1:0] COUNT_MAX = LIM_W'({COUNT_WIDTH{1'b1}});

	logic                   valid_s1;
	logic [7:0]             pins_s1;
	logic                   advance;
	logic [COUNT_WIDTH-1:0] limit_q;
	logic [LIM_W-1:0]       ticks_ext;
	logic [COUNT_WIDTH-1:0] limit_d;
	scan_result_t           step_res;
	scan_result_t           res_q;

	// Saturate to the counter range, treat zero as one.
	assign ticks_ext = LIM_W'(debounce_ticks);
	always_comb begin
		if (ticks_ext > COUNT_MAX) begin
			limit_d = COUNT_MAX[COUNT_WIDTH-1:0];
		end else if (ticks_ext == '0) begin
			limit_d = COUNT_WIDTH'(1);
		end else begin
			limit_d = ticks_ext[COUNT_WIDTH-1:0];
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= COUNT_WIDTH'(DEBOUNCE_RESET);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= limit_d;
		end
	end

	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			pins_s1 <= port_pins;
		end
	end

	mkls_fsm #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_fsm (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.pins  (pins_s1),
		.limit (limit_q),
		.result(step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= step_res;
		end
	end

	assign drive_pattern = res_q.drive_pattern;
	assign key_valid     = res_q.key_valid;
	assign key_code      = res_q.key_code;
	assign key_error     = res_q.key_error;

	// A report always returns the scanner to column drive.
	a_report_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && key_valid |-> drive_pattern == DRIVE_COLS)
		else $error("key report without return to column drive");

	// Error and code only travel with a report; an error carries code zero.
	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !key_valid |-> !key_error && key_code == 4'd0)
		else $error("key fields set without a report");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && key_error |-> key_code == 4'd0)
		else $error("error report with nonzero key code");

	// Drive is only ever one of the two line reversal patterns.
	a_drive_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> drive_pattern == DRIVE_COLS || drive_pattern == DRIVE_ROWS)
		else $error("illegal drive pattern");

endmodule
